// ----- hw/rtl/sha_pkg.sv -----
// shared types, constants and round functions for the sha-256 stream hash
`timescale 1ns / 1ps
package sha_pkg;

    localparam int WordW   = 32;
    localparam int NBytesW = 3;
    localparam int IdxW    = 3;
    localparam int PosW    = 4;
    localparam int RoundW  = 6;
    localparam int LenW    = 64;

    typedef logic [WordW-1:0] t_word;

    localparam t_word PadByteWord = 32'h8000_0000;

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // control from the framing logic to the compression core
    typedef struct packed {
        logic              wr_en;
        logic [PosW-1:0]   wr_addr;
        t_word             wr_data;
        logic              start;
        logic              init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic t_word ror(input t_word x, input int n);
        ror = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    // keep the valid upper lanes, place the 0x80 byte right after them
    function automatic t_word lane_mask(input logic [NBytesW-1:0] n);
        unique case (n)
            3'd0:    lane_mask = 32'h0000_0000;
            3'd1:    lane_mask = 32'hff00_0000;
            3'd2:    lane_mask = 32'hffff_0000;
            3'd3:    lane_mask = 32'hffff_ff00;
            default: lane_mask = 32'hffff_ffff;
        endcase
    endfunction

    function automatic t_word pad_word(input logic [NBytesW-1:0] n);
        unique case (n)
            3'd0:    pad_word = 32'h8000_0000;
            3'd1:    pad_word = 32'h0080_0000;
            3'd2:    pad_word = 32'h0000_8000;
            3'd3:    pad_word = 32'h0000_0080;
            default: pad_word = 32'h0000_0000;
        endcase
    endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
// stream channel interfaces for message words and digest words
`timescale 1ns / 1ps
interface sha_in_if import sha_pkg::*; ();
    logic                valid;
    logic                ready;
    t_word               message_word;
    logic [NBytesW-1:0]  valid_bytes;
    logic                last_item;

    modport source(output valid, message_word, valid_bytes, last_item, input ready);
    modport sink(input valid, message_word, valid_bytes, last_item, output ready);
endinterface

interface sha_out_if import sha_pkg::*; ();
    logic             valid;
    logic             ready;
    t_word            digest_word;
    logic [IdxW-1:0]  word_index;
    logic             last_word;

    modport source(output valid, digest_word, word_index, last_word, input ready);
    modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha256_stream_hash.sv -----
// top level: message framing, padding, length and digest output
// a non-last word is one transfer; every 16th buffered word starts a compression
// a last word adds one padding word per cycle (held while a block compresses),
// one or two compressions, then eight transfers; compression runs on the single round unit
// digest words come straight from the hash registers, one transfer per cycle when taken
// reset (synchronous, active low) loads the initial hash and clears length and word position
`timescale 1ns / 1ps
module sha256_stream_hash import sha_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha_in_if.sink       i_msg,
    sha_out_if.source    o_dig
);

    typedef enum logic [3:0] {
        S_IN   = 4'b0001,
        S_PAD  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_state              r_ret, n_ret;
    t_state              after;
    logic [PosW-1:0]     r_pos, n_pos;
    logic [LenW-1:0]     r_len, n_len;
    logic                r_need80, n_need80;
    logic                r_hi_sent, n_hi_sent;
    logic [IdxW-1:0]     r_idx, n_idx;
    logic                in_xfer;
    logic                push;
    t_word               push_word;
    logic [NBytesW-1:0]  nbytes;
    t_core_ctl           ctl;
    t_core_sts           sts;
    t_word               hash [8];

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_hash  (hash)
    );

    assign i_msg.ready = (r_state == S_IN);
    assign in_xfer     = i_msg.valid & i_msg.ready;

    // byte counts above four count as four
    assign nbytes = (i_msg.valid_bytes > 3'd4) ? 3'd4 : i_msg.valid_bytes;

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_pos     = r_pos;
        n_len     = r_len;
        n_need80  = r_need80;
        n_hi_sent = r_hi_sent;
        n_idx     = r_idx;
        after     = r_state;
        push      = 1'b0;
        push_word = '0;
        ctl       = '0;

        unique case (r_state)
            S_IN: begin
                if (in_xfer) begin
                    push = 1'b1;
                    if (i_msg.last_item) begin
                        push_word = (i_msg.message_word & lane_mask(nbytes)) | pad_word(nbytes);
                        n_len     = r_len + LenW'({nbytes, 3'b000});
                        n_need80  = (nbytes == 3'd4);
                        n_hi_sent = 1'b0;
                        after     = S_PAD;
                    end else begin
                        push_word = i_msg.message_word;
                        n_len     = r_len + LenW'(WordW);
                        after     = S_IN;
                    end
                end
            end
            S_PAD: begin
                // full last word: the 0x80 byte needs a word of its own; then zero words and the two length words
                push  = 1'b1;
                after = S_PAD;
                if (r_need80) begin
                    push_word = PadByteWord;
                    n_need80  = 1'b0;
                end else if (r_pos == 4'd14 && !r_hi_sent) begin
                    push_word = r_len[LenW-1:WordW];
                    n_hi_sent = 1'b1;
                end else if (r_pos == 4'd15 && r_hi_sent) begin
                    push_word = r_len[WordW-1:0];
                    after     = S_OUT;
                end
            end
            S_WAIT: begin
                if (sts.done) n_state = r_ret;
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == '1) begin
                        ctl.init = 1'b1;
                        n_len    = '0;
                        n_state  = S_IN;
                    end
                end
            end
            default: n_state = S_IN;
        endcase

        if (push) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = r_pos;
            ctl.wr_data = push_word;
            n_pos       = r_pos + 1'b1;
            // a full block hands over to the compression core
            if (r_pos == '1) begin
                ctl.start = 1'b1;
                n_state   = S_WAIT;
                n_ret     = after;
            end else begin
                n_state = after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_ret     <= S_IN;
            r_pos     <= '0;
            r_len     <= '0;
            r_need80  <= 1'b0;
            r_hi_sent <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_need80  <= n_need80;
            r_hi_sent <= n_hi_sent;
            r_idx     <= n_idx;
        end
    end

    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = hash[r_idx];
    assign o_dig.word_index  = r_idx;
    assign o_dig.last_word   = (r_idx == '1);

    a_out_idle_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid |-> !sts.busy) else $error("digest shown while compressing");
    a_out_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_pos == '0) else $error("digest with partial block");
    a_wait_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |=> r_state == S_WAIT && sts.busy) else $error("compression not started");

endmodule

// ----- hw/rtl/sha_core.sv -----
// block buffer memory, running hash and one-round-per-cycle compression
`timescale 1ns / 1ps
module sha_core import sha_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    output t_core_sts o_sts,
    output t_word     o_hash [8]
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_LOAD = 4'b0010,
        C_RUN  = 4'b0100,
        C_ADD  = 4'b1000
    } t_cstate;

    t_cstate            r_state, n_state;
    logic [RoundW-1:0]  r_round;
    t_word              r_blk [16];
    t_word              r_rdata;
    logic [PosW-1:0]    rd_addr;
    t_word              r_hash [8];
    t_word              r_v [8];
    t_word              r_sch [16];
    t_word              r_sched, n_sched;
    t_word              w, t1;

    // block buffer, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_blk[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_rdata <= r_blk[rd_addr];
    end

    // prefetch the word for the next round
    assign rd_addr = (r_state == C_LOAD) ? '0 : r_round[PosW-1:0] + 1'b1;

    // schedule word for the next round, registered to keep it off the round path
    assign n_sched = small_sigma1(r_sch[15]) + r_sch[10] + small_sigma0(r_sch[2]) + r_sch[1];
    assign w       = (r_round[RoundW-1:PosW] == '0) ? r_rdata : r_sched;
    assign t1      = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                   + RoundK[r_round] + w;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_ctl.start) n_state = C_LOAD;
            C_LOAD:  n_state = C_RUN;
            C_RUN:   if (r_round == '1) n_state = C_ADD;
            C_ADD:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == C_LOAD) begin
                r_round <= '0;
            end else if (r_state == C_RUN) begin
                r_round <= r_round + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= InitHash[i];
                r_v[i]    <= '0;
            end
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.init) begin
                        for (int i = 0; i < 8; i++) r_hash[i] <= InitHash[i];
                    end
                end
                C_LOAD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
                end
                C_RUN: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + big_sigma0(r_v[0])
                            + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
                end
                C_ADD: begin
                    for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
                end
                default: ;
            endcase
        end
    end

    // sliding window of the last sixteen schedule words
    always_ff @(posedge i_clk) begin
        if (r_state == C_RUN) begin
            for (int i = 0; i < 15; i++) r_sch[i] <= r_sch[i+1];
            r_sch[15] <= w;
            r_sched   <= n_sched;
        end
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = (r_state == C_ADD);
    assign o_hash     = r_hash;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == C_IDLE) else $error("start while compressing");
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_LOAD |=> r_state == C_RUN && r_round == '0)
        else $error("round counter not cleared");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_RUN || r_state == C_LOAD) |-> !i_ctl.wr_en)
        else $error("block buffer written during compression");

endmodule

// ----- test/sha256_stream_hash_tb.sv -----
// self-checking testbench for the sha-256 stream hash: directed table plus random messages
`timescale 1ns / 1ps
module sha256_stream_hash_tb;
    import sha_pkg::*;

    localparam int StallLimit = 20000;

    typedef struct packed {
        t_word           word;
        logic [NBytesW-1:0] nbytes;
        logic            last;
    } t_msg_item;

    typedef struct packed {
        t_word           word;
        logic [IdxW-1:0] idx;
        logic            last;
    } t_digest_item;

    // directed row: item plus an optional typed-in first digest word
    typedef struct packed {
        t_msg_item item;
        logic      has_known;
        t_word     known_word0;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  msg_ch ();
    sha_out_if dig_ch ();

    sha256_stream_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_ch.sink),
        .o_dig   (dig_ch.source)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    t_word       pred_hash [8];
    t_word       pred_block [16];
    int unsigned pred_pos;
    logic [63:0] pred_bitlen;

    t_digest_item digest_queue [$];
    t_msg_item    send_queue [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           recv_hold;
    int           idle_cycles;

    function automatic t_word rot(input t_word x, input int n);
        rot = (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_pred();
        t_word w [64];
        t_word v [8];
        t_word t1, t2;
        for (int i = 0; i < 16; i++) w[i] = pred_block[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = pred_hash[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int k = 7; k > 0; k--) v[k] = v[k-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) pred_hash[i] += v[i];
    endtask

    task automatic append_word(input t_word w);
        pred_block[pred_pos] = w;
        pred_pos = (pred_pos + 1) % 16;
        if (pred_pos == 0) compress_pred();
    endtask

    task automatic hash_reset_pred();
        for (int i = 0; i < 8; i++) pred_hash[i] = InitHash[i];
        pred_pos    = 0;
        pred_bitlen = '0;
    endtask

    // fold one accepted message word into the running hash; a last word yields the digest
    task automatic absorb_word(input t_msg_item it);
        int unsigned n;
        t_word mask, pad;
        if (!it.last) begin
            pred_bitlen += 32;
            append_word(it.word);
        end else begin
            n = (it.nbytes > 4) ? 4 : it.nbytes;
            mask = (n == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * n));
            pad  = (n == 4) ? 32'h0 : (32'h8000_0000 >> (8 * n));
            pred_bitlen += 8 * n;
            append_word((it.word & mask) | pad);
            if (n == 4) append_word(32'h8000_0000);
            while (pred_pos != 14) append_word(32'h0);
            append_word(pred_bitlen[63:32]);
            append_word(pred_bitlen[31:0]);
            for (int i = 0; i < 8; i++)
                digest_queue.push_back('{pred_hash[i], i[IdxW-1:0], i == 7});
            hash_reset_pred();
        end
    endtask

    // input driver: sender idles at random, never drops valid inside a step
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_ch.valid <= 1'b0;
        end else begin
            if (msg_ch.valid && msg_ch.ready) begin
                absorb_word('{msg_ch.message_word, msg_ch.valid_bytes, msg_ch.last_item});
                void'(send_queue.pop_front());
            end
            if ((!msg_ch.valid || msg_ch.ready) && send_queue.size() > 0
                    && !(msg_ch.valid && msg_ch.ready && send_queue.size() == 0)) begin
                // front entry is the next item once the accepted one was popped
                if ($urandom_range(99) >= send_idle_pct) begin
                    msg_ch.valid        <= 1'b1;
                    msg_ch.message_word <= send_queue[0].word;
                    msg_ch.valid_bytes  <= send_queue[0].nbytes;
                    msg_ch.last_item    <= send_queue[0].last;
                end else begin
                    msg_ch.valid <= 1'b0;
                end
            end else if (msg_ch.valid && msg_ch.ready) begin
                msg_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dig_ch.ready <= 1'b0;
        end else begin
            dig_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        t_digest_item exp_item;
        if (i_rst_n) begin
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (dig_ch.valid && dig_ch.ready) begin
                if (digest_queue.size() == 0) begin
                    $error("digest transfer with nothing expected: %h", dig_ch.digest_word);
                    error_count++;
                end else begin
                    exp_item = digest_queue.pop_front();
                    if (dig_ch.digest_word !== exp_item.word) begin
                        $error("digest_word expected %h actual %h",
                               exp_item.word, dig_ch.digest_word);
                        error_count++;
                    end
                    if (dig_ch.word_index !== exp_item.idx) begin
                        $error("word_index expected %0d actual %0d",
                               exp_item.idx, dig_ch.word_index);
                        error_count++;
                    end
                    if (dig_ch.last_word !== exp_item.last) begin
                        $error("last_word expected %0d actual %0d",
                               exp_item.last, dig_ch.last_word);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= StallLimit && !recv_hold) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_msg_item rand_item(input bit last);
        t_msg_item it;
        it.word   = $urandom;
        it.nbytes = $urandom_range(7);
        it.last   = last;
        return it;
    endfunction

    // queue a random message of the given word count
    task automatic queue_message(input int words);
        for (int i = 0; i < words - 1; i++) send_queue.push_back(rand_item(1'b0));
        send_queue.push_back(rand_item(1'b1));
    endtask

    task automatic wait_drained();
        while (send_queue.size() > 0 || msg_ch.valid || digest_queue.size() > 0)
            @(posedge i_clk);
    endtask

    // directed rows: "abc" and the empty message have well-known first digest words
    t_dir_row dir_rows [] = '{
        '{'{32'h6162_63ff, 3'd3, 1'b1}, 1'b1, 32'hba78_16bf},  // "abc", junk lane cleared
        '{'{32'hdead_beef, 3'd0, 1'b1}, 1'b1, 32'he3b0_c442},  // empty message
        '{'{32'hffff_ffff, 3'd7, 1'b1}, 1'b0, 32'h0},          // count above four saturates
        '{'{32'h0000_0000, 3'd4, 1'b1}, 1'b0, 32'h0},
        '{'{32'hffff_ffff, 3'd1, 1'b0}, 1'b0, 32'h0},          // count ignored on non-last
        '{'{32'h8000_0001, 3'd2, 1'b1}, 1'b0, 32'h0},
        '{'{32'h0123_4567, 3'd5, 1'b0}, 1'b0, 32'h0},
        '{'{32'h89ab_cdef, 3'd1, 1'b1}, 1'b0, 32'h0}
    };

    initial begin
        int phase_items;
        int len;
        msg_ch.valid        = 1'b0;
        msg_ch.message_word = '0;
        msg_ch.valid_bytes  = '0;
        msg_ch.last_item    = 1'b0;
        dig_ch.ready        = 1'b0;
        i_rst_n        = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        hash_reset_pred();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, with typed-in first words checked against the predictor too
        foreach (dir_rows[r]) begin
            send_queue.push_back(dir_rows[r].item);
            if (dir_rows[r].has_known) begin
                wait_drained();
            end
        end
        // the typed-in words are compared below, after the whole table has drained
        wait_drained();
        // check known vectors by pushing through the predictor independently
        foreach (dir_rows[r]) if (dir_rows[r].has_known) begin
            hash_reset_pred();
            absorb_word(dir_rows[r].item);
            if (digest_queue[0].word !== dir_rows[r].known_word0) begin
                $error("digest_word expected %h actual %h",
                       dir_rows[r].known_word0, digest_queue[0].word);
                error_count++;
            end
            digest_queue.delete();
        end
        // a 55/56-byte boundary pair: 55 bytes fit one block, 56 bytes exercise the two-block tail
        send_queue.push_back(rand_item(1'b0));
        for (int i = 0; i < 12; i++) send_queue.push_back(rand_item(1'b0));
        send_queue.push_back('{32'h1234_5678, 3'd3, 1'b1});
        for (int i = 0; i < 13; i++) send_queue.push_back(rand_item(1'b0));
        send_queue.push_back('{32'h1234_5678, 3'd4, 1'b1});
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 21 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 21 : 0;
            phase_items = 0;
            while (phase_items < 85) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 17);
                queue_message(len);
                phase_items += len;
            end
            if (ph == 0) begin
                // long receiver hold-off, timed by its own process while the sender keeps offering
                recv_hold = 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
